### hw/rtl/bos_pkg.sv
// bos_pkg: types and constants shared by the bulk-only transport sequencer
// no dependencies; compile first

package bos_pkg;

	typedef enum logic [2:0] {
		FS_OK      = 3'd0,
		FS_RANGE   = 3'd1,
		FS_FAILED  = 3'd2,
		FS_PROTO   = 3'd3,
		FS_RESIDUE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_CAPACITY    = 2'd0,
		CFG_BLOCK_BYTES = 2'd1,
		CFG_MAX_CHUNK   = 2'd2,
		CFG_UNIT        = 2'd3
	} cfg_idx_t;

	localparam logic       FUNC_START  = 1'b0;
	localparam logic       FUNC_STATUS = 1'b1;

	localparam logic [31:0] ST_SIG_USBS    = 32'h5342_5355;
	localparam logic [7:0]  ST_CODE_PASSED = 8'h00;
	localparam logic [7:0]  ST_CODE_FAILED = 8'h01;

	localparam logic [7:0] OP_READ10  = 8'h28;
	localparam logic [7:0] OP_WRITE10 = 8'h2A;
	localparam logic [7:0] OP_READ12  = 8'hA8;
	localparam logic [7:0] OP_WRITE12 = 8'hAA;
	localparam logic [7:0] OP_READ16  = 8'h88;
	localparam logic [7:0] OP_WRITE16 = 8'h8A;

	localparam logic [31:0] TAG_RESET         = 32'd8;
	localparam logic [63:0] CAPACITY_RESET    = 64'd0;
	localparam logic [16:0] BLOCK_BYTES_RESET = 17'd512;
	localparam logic [31:0] MAX_CHUNK_RESET   = 32'd128;
	localparam logic [3:0]  UNIT_RESET        = 4'd0;

	typedef struct packed {
		logic [63:0] capacity;
		logic [16:0] block_bytes;
		logic [31:0] max_chunk;
		logic [3:0]  unit;
	} cfg_t;

	typedef struct packed {
		logic        func;
		logic [63:0] start_block;
		logic [31:0] block_count;
		logic        is_write;
		logic [31:0] status_signature;
		logic [31:0] status_tag;
		logic [7:0]  status_code;
		logic [31:0] status_residue;
	} req_t;

	typedef struct packed {
		logic [31:0] blocks_left;
		logic [63:0] next_lba;
		logic        writing;
		logic [31:0] send_tag;
		logic [31:0] expect_tag;
	} seq_state_t;

	// result before the byte count is formed
	typedef struct packed {
		logic        is_done;
		logic [31:0] tag;
		logic        dir_in;
		logic [7:0]  opcode;
		logic [63:0] lba;
		logic [31:0] chunk;
		logic [3:0]  unit;
		status_t     status;
		logic        reset_needed;
	} stage_t;

endpackage

### hw/rtl/bos_req_if.sv
// bos_req_if: request channel, start requests and status wrappers
// no dependencies

interface bos_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] start_block;
	logic [31:0] block_count;
	logic        is_write;
	logic [31:0] status_signature;
	logic [31:0] status_tag;
	logic [7:0]  status_code;
	logic [31:0] status_residue;

	modport source (
		output valid, func, start_block, block_count, is_write,
		output status_signature, status_tag, status_code, status_residue,
		input  ready
	);
	modport sink (
		input  valid, func, start_block, block_count, is_write,
		input  status_signature, status_tag, status_code, status_residue,
		output ready
	);
endinterface

### hw/rtl/bos_res_if.sv
// bos_res_if: result channel, command wrappers and final status
// no dependencies

interface bos_res_if;
	logic        valid;
	logic        ready;
	logic        is_done;
	logic [31:0] cmd_tag;
	logic [31:0] cmd_bytes;
	logic        cmd_dir_in;
	logic [7:0]  cmd_opcode;
	logic [63:0] cmd_lba;
	logic [31:0] cmd_blocks;
	logic [3:0]  cmd_unit;
	logic [2:0]  final_status;
	logic        reset_needed;

	modport source (
		output valid, is_done, cmd_tag, cmd_bytes, cmd_dir_in, cmd_opcode,
		output cmd_lba, cmd_blocks, cmd_unit, final_status, reset_needed,
		input  ready
	);
	modport sink (
		input  valid, is_done, cmd_tag, cmd_bytes, cmd_dir_in, cmd_opcode,
		input  cmd_lba, cmd_blocks, cmd_unit, final_status, reset_needed,
		output ready
	);
endinterface

### hw/rtl/bos_step.sv
// bos_step: per-transaction decision logic, range check, status check, chunking
// depends on bos_pkg

module bos_step (
	input  bos_pkg::req_t       item,
	input  bos_pkg::seq_state_t st,
	input  bos_pkg::cfg_t       cfg,
	output bos_pkg::stage_t     res,
	output bos_pkg::seq_state_t st_nxt
);

	logic [31:0] lim;
	logic [31:0] chunk_new;
	logic [31:0] chunk_cur;
	logic [63:0] room;
	logic        range_bad;
	logic        cap_big;

	assign lim       = (cfg.max_chunk == '0) ? 32'd1 : cfg.max_chunk;
	// both chunk candidates in parallel, selected below
	assign chunk_new = (item.block_count < lim) ? item.block_count : lim;
	assign chunk_cur = (st.blocks_left < lim) ? st.blocks_left : lim;
	assign room      = cfg.capacity - item.start_block;
	assign range_bad = (item.start_block >= cfg.capacity) ||
	                   (room < {32'd0, item.block_count});
	assign cap_big   = (cfg.capacity[63:32] != '0);

	always_comb begin
		logic        is_cmd;
		logic        wr;
		logic [31:0] left;
		logic [63:0] lba;
		logic [31:0] chunk;

		st_nxt = st;
		res = '0;
		res.is_done = 1'b1;
		res.status = bos_pkg::FS_OK;
		is_cmd = 1'b0;
		wr = st.writing;
		left = st.blocks_left;
		lba = st.next_lba;
		chunk = chunk_cur;

		case (item.func)
			bos_pkg::FUNC_START: begin
				if (range_bad) begin
					res.status = bos_pkg::FS_RANGE;
				end else begin
					wr = item.is_write;
					left = item.block_count;
					lba = item.start_block;
					chunk = chunk_new;
					st_nxt.writing = item.is_write;
					st_nxt.next_lba = item.start_block;
					is_cmd = (item.block_count != '0);
				end
			end
			bos_pkg::FUNC_STATUS: begin
				if (item.status_signature != bos_pkg::ST_SIG_USBS) begin
					res.status = bos_pkg::FS_PROTO;
					res.reset_needed = 1'b1;
				end else begin
					st_nxt.expect_tag = st.expect_tag + 32'd1;
					if (item.status_tag != st.expect_tag) begin
						res.status = bos_pkg::FS_PROTO;
						res.reset_needed = 1'b1;
					end else if (item.status_code == bos_pkg::ST_CODE_FAILED) begin
						res.status = bos_pkg::FS_FAILED;
					end else if (item.status_code != bos_pkg::ST_CODE_PASSED) begin
						res.status = bos_pkg::FS_PROTO;
						res.reset_needed = 1'b1;
					end else if (item.status_residue != '0) begin
						res.status = bos_pkg::FS_RESIDUE;
					end else begin
						is_cmd = (st.blocks_left != '0);
					end
				end
			end
			default: begin
			end
		endcase

		// any final status leaves nothing pending
		st_nxt.blocks_left = '0;
		if (is_cmd) begin
			res.is_done = 1'b0;
			res.tag = st.send_tag;
			res.dir_in = ~wr;
			res.lba = lba;
			res.chunk = chunk;
			res.unit = cfg.unit;
			if (cap_big) begin
				res.opcode = wr ? bos_pkg::OP_WRITE16 : bos_pkg::OP_READ16;
			end else if (chunk[31:16] == '0) begin
				res.opcode = wr ? bos_pkg::OP_WRITE10 : bos_pkg::OP_READ10;
			end else begin
				res.opcode = wr ? bos_pkg::OP_WRITE12 : bos_pkg::OP_READ12;
			end
			st_nxt.send_tag = st.send_tag + 32'd1;
			st_nxt.blocks_left = left - chunk;
			st_nxt.next_lba = lba + {32'd0, chunk};
		end
	end

endmodule

### hw/rtl/bulk_only_scsi_rw_sequencer_top.sv
// throughput: one transaction per cycle unless the output stalls; st_q updates in stage 1
// stages: input register, decision register, then byte count multiply into the output register
// reset: arst_n clears the stage valid flags, sequence state (tags to 8) and config to defaults
// depends on bos_pkg, bos_req_if, bos_res_if, bos_step

module bulk_only_scsi_rw_sequencer_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_wdata,
	bos_req_if.sink      req,
	bos_res_if.source    res
);

	bos_pkg::cfg_t       cfg_q;
	bos_pkg::seq_state_t st_q;
	bos_pkg::seq_state_t st_nxt;
	bos_pkg::req_t       req_s1;
	bos_pkg::stage_t     step_res;
	bos_pkg::stage_t     res_s2;
	bos_pkg::stage_t     out_q;
	logic [31:0]         bytes_q;
	logic [48:0]         prod;
	logic                v_s1;
	logic                v_s2;
	logic                out_v_q;
	logic                en_out;
	logic                en_s2;
	logic                en_s1;
	logic                adv_s1;

	assign en_out = ~out_v_q | res.ready;
	assign en_s2  = ~v_s2 | en_out;
	assign en_s1  = ~v_s1 | en_s2;
	assign adv_s1 = v_s1 & en_s2;

	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity    <= bos_pkg::CAPACITY_RESET;
			cfg_q.block_bytes <= bos_pkg::BLOCK_BYTES_RESET;
			cfg_q.max_chunk   <= bos_pkg::MAX_CHUNK_RESET;
			cfg_q.unit        <= bos_pkg::UNIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bos_pkg::CFG_CAPACITY:    cfg_q.capacity    <= cfg_wdata;
				bos_pkg::CFG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_wdata[16:0];
				bos_pkg::CFG_MAX_CHUNK:   cfg_q.max_chunk   <= cfg_wdata[31:0];
				bos_pkg::CFG_UNIT:        cfg_q.unit        <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= req.valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_out) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && req.valid) begin
			req_s1.func             <= req.func;
			req_s1.start_block      <= req.start_block;
			req_s1.block_count      <= req.block_count;
			req_s1.is_write         <= req.is_write;
			req_s1.status_signature <= req.status_signature;
			req_s1.status_tag       <= req.status_tag;
			req_s1.status_code      <= req.status_code;
			req_s1.status_residue   <= req.status_residue;
		end
		if (adv_s1) begin
			res_s2 <= step_res;
		end
		if (en_out && v_s2) begin
			out_q <= res_s2;
			bytes_q <= prod[31:0];
		end
	end

	bos_step u_step (
		.item   (req_s1),
		.st     (st_q),
		.cfg    (cfg_q),
		.res    (step_res),
		.st_nxt (st_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.blocks_left <= '0;
			st_q.next_lba    <= '0;
			st_q.writing     <= 1'b0;
			st_q.send_tag    <= bos_pkg::TAG_RESET;
			st_q.expect_tag  <= bos_pkg::TAG_RESET;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// done results carry a zero chunk, so the byte count comes out zero
	assign prod = res_s2.chunk * cfg_q.block_bytes;

	assign res.valid        = out_v_q;
	assign res.is_done      = out_q.is_done;
	assign res.cmd_tag      = out_q.tag;
	assign res.cmd_bytes    = bytes_q;
	assign res.cmd_dir_in   = out_q.dir_in;
	assign res.cmd_opcode   = out_q.opcode;
	assign res.cmd_lba      = out_q.lba;
	assign res.cmd_blocks   = out_q.chunk;
	assign res.cmd_unit     = out_q.unit;
	assign res.final_status = out_q.status;
	assign res.reset_needed = out_q.reset_needed;

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && step_res.is_done) |=> (st_q.blocks_left == '0))
		else $error("blocks_left not cleared after final status");

	a_tag_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !step_res.is_done) |=> (st_q.send_tag == $past(st_q.send_tag) + 32'd1))
		else $error("send tag did not advance on command wrapper");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.is_done) |-> (bytes_q == '0 && out_q.opcode == '0))
		else $error("final status carries command fields");

	a_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.is_done) |->
		(out_q.status == bos_pkg::FS_OK && !out_q.reset_needed && out_q.chunk != '0))
		else $error("command wrapper carries status or empty chunk");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && out_v_q && !res.ready) |-> !req.ready)
		else $error("request accepted while pipeline is full and stalled");

endmodule
